// ----- sv/isf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// isf_pkg
// Shared types and constants of the inductor sample filter.
// ----------------------------------------------------------------------------
package isf_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int SAMPLE_MAX = 1023;
	localparam int CH_W       = 2;
	localparam int NUM_FILT   = 3;
	localparam int SCALED_W   = 16;
	localparam int DVD_W      = 17;
	localparam int DIV_STEPS  = 17;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
	localparam int TRIM_W     = 12;
	localparam int THIRD_K    = 14;
	localparam int THIRD_M_W  = 13;

	localparam logic [CH_W-1:0]      CH_VERT   = 2'd3;
	localparam logic [DVD_W-1:0]     PERCENT   = 17'd100;
	localparam logic [THIRD_M_W-1:0] THIRD_M   = 13'd5462;
	localparam logic [SAMPLE_W-1:0]  FS_RESET  = 10'd1023;

	typedef struct packed {
		logic                start;
		logic [DVD_W-1:0]    dividend;
		logic [SAMPLE_W-1:0] divisor;
	} isf_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} isf_div_rsp_t;

endpackage
`default_nettype wire

// ----- sv/isf_win_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// isf_win_mem
// History window storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module isf_win_mem #(
	parameter int DEPTH  = 12,
	parameter int ADDR_W = 4
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [ADDR_W-1:0]             wr_addr,
	input  wire logic [isf_pkg::SAMPLE_W-1:0]  wr_data,
	input  wire logic                          rd_en,
	input  wire logic [ADDR_W-1:0]             rd_addr_a,
	input  wire logic [ADDR_W-1:0]             rd_addr_b,
	output logic      [isf_pkg::SAMPLE_W-1:0]  rd_data_a,
	output logic      [isf_pkg::SAMPLE_W-1:0]  rd_data_b
);
	import isf_pkg::*;

	logic [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule
`default_nettype wire

// ----- sv/isf_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// isf_div
// Restoring divider, one quotient bit per cycle; divide by zero gives all ones.
// ----------------------------------------------------------------------------
module isf_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire isf_pkg::isf_div_req_t req,
	output isf_pkg::isf_div_rsp_t      rsp
);
	import isf_pkg::*;

	logic [DVD_W-1:0]     dq_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [SAMPLE_W-1:0]  dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [SAMPLE_W:0]    rem_sh;
	logic [SAMPLE_W:0]    rem_diff;
	logic                 ge;

	assign rem_sh   = {rem_q, dq_q[DVD_W-1]};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign rem_diff = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DVD_W-2:0], ge};
			rem_q <= ge ? rem_diff[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule
`default_nettype wire

// ----- sv/inductor_sample_filter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// inductor_sample_filter_unit
// Per-channel trimmed-mean moving-average filter with percent scaling.
// ----------------------------------------------------------------------------
// One word is processed at a time. A channel 0 to 2 word passes from acceptance
// to result through trim, divide by three, spike check and window update,
// window mean, then the shared restoring divider for the percent scaling; a
// channel 3 word skips the filter and goes straight to the scaling. The next
// word is taken only once the result has moved into the output register, so a
// stalled output side holds off new words. The window entries sit in a small
// RAM; per-entry valid bits make never-written entries read as zero, so no
// clearing pass is needed.
module inductor_sample_filter_unit #(
	parameter int WINDOW_LEN = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [isf_pkg::SAMPLE_W-1:0]  cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [isf_pkg::CH_W-1:0]      channel,
	input  wire logic [isf_pkg::SAMPLE_W-1:0]  sample_a,
	input  wire logic [isf_pkg::SAMPLE_W-1:0]  sample_b,
	input  wire logic [isf_pkg::SAMPLE_W-1:0]  sample_c,
	input  wire logic [isf_pkg::SAMPLE_W-1:0]  sample_d,
	input  wire logic [isf_pkg::SAMPLE_W-1:0]  sample_e,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [isf_pkg::CH_W-1:0]      out_channel,
	output logic      [isf_pkg::SAMPLE_W-1:0]  filtered_level,
	output logic      [isf_pkg::SCALED_W-1:0]  scaled_level
);
	import isf_pkg::*;

	localparam int PTR_W    = $clog2(WINDOW_LEN);
	localparam int DEPTH    = NUM_FILT * WINDOW_LEN;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int SUM_W    = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);
	localparam int AVG_K    = SUM_W + $clog2(WINDOW_LEN);
	localparam int AVG_M    = ((1 << AVG_K) + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam int AVG_M_W  = SUM_W + 1;
	localparam int AVG_P_W  = SUM_W + AVG_M_W;
	localparam int THIRD_P_W = TRIM_W + THIRD_M_W;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_TRIM  = 8'b0000_0010,
		ST_THIRD = 8'b0000_0100,
		ST_SPIKE = 8'b0000_1000,
		ST_AVG   = 8'b0001_0000,
		ST_SCALE = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	function automatic logic [TRIM_W-1:0] trim_sum(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b,
		input logic [SAMPLE_W-1:0] c,
		input logic [SAMPLE_W-1:0] d,
		input logic [SAMPLE_W-1:0] e
	);
		logic [SAMPLE_W-1:0] v [5];
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [TRIM_W:0]     sum;
		v[0] = a;
		v[1] = b;
		v[2] = c;
		v[3] = d;
		v[4] = e;
		lo   = v[0];
		hi   = v[0];
		sum  = '0;
		for (int i = 0; i < 5; i++) begin
			sum = sum + (TRIM_W + 1)'(v[i]);
			if (v[i] < lo) begin
				lo = v[i];
			end
			if (v[i] > hi) begin
				hi = v[i];
			end
		end
		sum = sum - (TRIM_W + 1)'(lo) - (TRIM_W + 1)'(hi);
		return sum[TRIM_W-1:0];
	endfunction

	state_t               state_q;
	logic [SAMPLE_W-1:0]  full_scale_q;
	logic [CH_W-1:0]      ch_q;
	logic [SAMPLE_W-1:0]  samp_a_q, samp_b_q, samp_c_q, samp_d_q, samp_e_q;
	logic [PTR_W-1:0]     head_q [NUM_FILT];
	logic [SUM_W-1:0]     sum_q  [NUM_FILT];
	logic [DEPTH-1:0]     valid_q;
	logic                 old_vld_q;
	logic                 new_vld_q;
	logic [TRIM_W-1:0]    tm_sum_q;
	logic [SAMPLE_W-1:0]  tm_val_q;
	logic [SUM_W-1:0]     sum_new_q;
	logic [SAMPLE_W-1:0]  level_q;
	logic [SCALED_W-1:0]  res_scaled_q;
	logic                 out_valid_q;
	logic [CH_W-1:0]      out_channel_q;
	logic [SAMPLE_W-1:0]  filtered_q;
	logic [SCALED_W-1:0]  scaled_q;

	logic                 accept;
	logic [1:0]           in_ch_idx;
	logic [PTR_W-1:0]     in_head;
	logic [PTR_W-1:0]     in_newest;
	logic [ADDR_W-1:0]    in_base;
	logic [ADDR_W-1:0]    rd_addr_old;
	logic [ADDR_W-1:0]    rd_addr_new;
	logic                 mem_rd_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic                 mem_wr_en;
	logic [SAMPLE_W-1:0]  rd_old;
	logic [SAMPLE_W-1:0]  rd_new;
	logic [SAMPLE_W-1:0]  oldest_v;
	logic [SAMPLE_W-1:0]  newest_v;
	logic                 spike;
	logic [SAMPLE_W-1:0]  new_val;
	logic [SUM_W:0]       sum_calc;
	logic [THIRD_P_W-1:0] third_prod;
	logic [AVG_P_W-1:0]   avg_prod;
	logic                 out_load;
	isf_div_req_t         div_req;
	isf_div_rsp_t         div_rsp;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// window addressing at acceptance
	assign in_ch_idx   = channel;
	assign in_head     = head_q[in_ch_idx];
	assign in_newest   = (in_head == '0) ? PTR_W'(WINDOW_LEN - 1) : in_head - 1'b1;
	assign in_base     = ADDR_W'(channel) * ADDR_W'(WINDOW_LEN);
	assign rd_addr_old = in_base + ADDR_W'(in_head);
	assign rd_addr_new = in_base + ADDR_W'(in_newest);
	assign mem_rd_en   = accept && (channel != CH_VERT);

	assign wr_addr   = ADDR_W'(ch_q) * ADDR_W'(WINDOW_LEN) + ADDR_W'(head_q[ch_q]);
	assign mem_wr_en = (state_q == ST_SPIKE);

	// spike rejection and running sum update
	assign oldest_v = old_vld_q ? rd_old : '0;
	assign newest_v = new_vld_q ? rd_new : '0;
	assign spike    = {1'b0, tm_val_q} > ({1'b0, newest_v} + {2'b00, full_scale_q[SAMPLE_W-1:1]});
	assign new_val  = spike ? newest_v : tm_val_q;
	assign sum_calc = (SUM_W + 1)'(sum_q[ch_q]) + (SUM_W + 1)'(new_val)
		- (SUM_W + 1)'(oldest_v);

	assign third_prod = THIRD_P_W'(tm_sum_q) * THIRD_P_W'(THIRD_M);
	assign avg_prod   = AVG_P_W'(sum_new_q) * AVG_P_W'(AVG_M);

	assign div_req.start    = (state_q == ST_SCALE);
	assign div_req.dividend = DVD_W'(level_q) * PERCENT;
	assign div_req.divisor  = full_scale_q;

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	isf_win_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_win_mem (
		.clk       (clk),
		.wr_en     (mem_wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (new_val),
		.rd_en     (mem_rd_en),
		.rd_addr_a (rd_addr_old),
		.rd_addr_b (rd_addr_new),
		.rd_data_a (rd_old),
		.rd_data_b (rd_new)
	);

	isf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FS_RESET;
		end else if (cfg_wr_en) begin
			full_scale_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			for (int i = 0; i < NUM_FILT; i++) begin
				head_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (channel == CH_VERT) ? ST_SCALE : ST_TRIM;
					end
				end
				ST_TRIM: begin
					state_q <= ST_THIRD;
				end
				ST_THIRD: begin
					state_q <= ST_SPIKE;
				end
				ST_SPIKE: begin
					valid_q[wr_addr] <= 1'b1;
					sum_q[ch_q]      <= sum_calc[SUM_W-1:0];
					head_q[ch_q]     <= (head_q[ch_q] == PTR_W'(WINDOW_LEN - 1)) ?
						'0 : head_q[ch_q] + 1'b1;
					state_q          <= ST_AVG;
				end
				ST_AVG: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q      <= channel;
			samp_a_q  <= sample_a;
			samp_b_q  <= sample_b;
			samp_c_q  <= sample_c;
			samp_d_q  <= sample_d;
			samp_e_q  <= sample_e;
			level_q   <= sample_a;
			old_vld_q <= valid_q[rd_addr_old];
			new_vld_q <= valid_q[rd_addr_new];
		end
		if (state_q == ST_TRIM) begin
			tm_sum_q <= trim_sum(samp_a_q, samp_b_q, samp_c_q, samp_d_q, samp_e_q);
		end
		if (state_q == ST_THIRD) begin
			tm_val_q <= third_prod[THIRD_K +: SAMPLE_W];
		end
		if (state_q == ST_SPIKE) begin
			sum_new_q <= sum_calc[SUM_W-1:0];
		end
		if (state_q == ST_AVG) begin
			level_q <= avg_prod[AVG_K +: SAMPLE_W];
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			res_scaled_q <= (div_rsp.quotient[DVD_W-1:SCALED_W] != '0) ?
				'1 : div_rsp.quotient[SCALED_W-1:0];
		end
		if (out_load) begin
			out_channel_q <= ch_q;
			filtered_q    <= level_q;
			scaled_q      <= res_scaled_q;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_channel    = out_channel_q;
	assign filtered_level = filtered_q;
	assign scaled_level   = scaled_q;

	a_wr_not_vert: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (ch_q != CH_VERT))
		else $error("window write for the scale-only channel");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_vert_skips_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (channel == CH_VERT)) |=> (state_q == ST_SCALE))
		else $error("scale-only word entered the filter path");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AVG) |-> (sum_new_q <= SUM_W'(WINDOW_LEN * SAMPLE_MAX)))
		else $error("window sum out of range");

	a_out_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && out_valid_q && !out_ready) |=> (state_q == ST_OUT))
		else $error("result overwrote a pending output word");

endmodule
`default_nettype wire

// ----- test/tb_inductor_sample_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inductor_sample_filter_unit
// Self-checking bench for the inductor sample filter. A local model keeps its
// own per-channel windows and full scale, predicts each word's result when
// the word is accepted, and the result side compares every output word field
// by field in order. Directed words cover trimming, the spike limit, the
// vertical channel, scaling overflow and zero full scale; random words then
// run under several full-scale settings and idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_inductor_sample_filter_unit;

	localparam int WIN            = 4;
	localparam int STALL_LIMIT    = 5000;
	localparam int REPORT_LIMIT   = 10;
	localparam int BLOCK_WORDS    = 50;
	localparam int SCALED_SAT     = 65535;
	localparam int PERCENT_FACTOR = 100;

	localparam logic [isf_pkg::CH_W-1:0] CH_LEFT   = 2'd0;
	localparam logic [isf_pkg::CH_W-1:0] CH_MIDDLE = 2'd1;
	localparam logic [isf_pkg::CH_W-1:0] CH_RIGHT  = 2'd2;

	typedef logic [isf_pkg::SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [isf_pkg::CH_W-1:0]     ch;
		sample_t                      level;
		logic [isf_pkg::SCALED_W-1:0] scaled;
	} level_result_t;

	logic    clk;
	logic    arst_n;
	logic    cfg_wr_en;
	sample_t cfg_wr_data;
	logic    in_valid;
	logic    in_ready;
	logic [isf_pkg::CH_W-1:0] channel;
	sample_t sample_a;
	sample_t sample_b;
	sample_t sample_c;
	sample_t sample_d;
	sample_t sample_e;
	logic    out_valid;
	logic    out_ready = 1'b0;
	logic [isf_pkg::CH_W-1:0]     out_channel;
	sample_t                      filtered_level;
	logic [isf_pkg::SCALED_W-1:0] scaled_level;

	sample_t       window_model [3][WIN];
	sample_t       full_scale_model;
	level_result_t pending_levels [$];
	int            drift_level [3];
	int            send_idle_pct;
	int            recv_idle_pct;
	int            mismatch_count = 0;
	int            stall_cycles = 0;

	inductor_sample_filter_unit #(
		.WINDOW_LEN(WIN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.channel(channel),
		.sample_a(sample_a),
		.sample_b(sample_b),
		.sample_c(sample_c),
		.sample_d(sample_d),
		.sample_e(sample_e),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_channel(out_channel),
		.filtered_level(filtered_level),
		.scaled_level(scaled_level)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic level_result_t predict_filtered_level(input logic [1:0] ch,
			input sample_t sa, input sample_t sb, input sample_t sc,
			input sample_t sd, input sample_t se);
		level_result_t r;
		sample_t       smp [5];
		int unsigned   sum;
		int unsigned   lo;
		int unsigned   hi;
		int unsigned   val;
		int unsigned   newest;
		int unsigned   lvl;
		int unsigned   q;
		smp = '{sa, sb, sc, sd, se};
		if (ch == isf_pkg::CH_VERT) begin
			lvl = sa;
		end else begin
			sum = 0;
			lo  = isf_pkg::SAMPLE_MAX;
			hi  = 0;
			foreach (smp[i]) begin
				sum += smp[i];
				if (smp[i] < lo) lo = smp[i];
				if (smp[i] > hi) hi = smp[i];
			end
			val    = (sum - lo - hi) / 3;
			newest = window_model[ch][WIN-1];
			// spike check on the signed difference, so a drop always passes
			if (int'(val) - int'(newest) > int'(full_scale_model / 2))
				val = newest;
			for (int i = 0; i < WIN - 1; i++)
				window_model[ch][i] = window_model[ch][i+1];
			window_model[ch][WIN-1] = val[isf_pkg::SAMPLE_W-1:0];
			sum = 0;
			for (int i = 0; i < WIN; i++)
				sum += window_model[ch][i];
			lvl = sum / WIN;
		end
		if (full_scale_model == 0) begin
			q = SCALED_SAT;
		end else begin
			q = lvl * PERCENT_FACTOR / full_scale_model;
			if (q > SCALED_SAT) q = SCALED_SAT;
		end
		r.ch     = ch;
		r.level  = lvl[isf_pkg::SAMPLE_W-1:0];
		r.scaled = q[isf_pkg::SCALED_W-1:0];
		return r;
	endfunction

	function automatic sample_t clip_sample(input int v);
		if (v < 0) return '0;
		if (v > isf_pkg::SAMPLE_MAX) return sample_t'(isf_pkg::SAMPLE_MAX);
		return sample_t'(v);
	endfunction

	task automatic send_word(input logic [1:0] ch, input sample_t sa, input sample_t sb,
			input sample_t sc, input sample_t sd, input sample_t se);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		channel  <= ch;
		sample_a <= sa;
		sample_b <= sb;
		sample_c <= sc;
		sample_d <= sd;
		sample_e <= se;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_levels.push_back(predict_filtered_level(ch, sa, sb, sc, sd, se));
	endtask

	// hold the sender until every predicted word has come out
	task automatic drain_results;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_levels.size() != 0);
	endtask

	task automatic write_full_scale(input sample_t v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en        <= 1'b0;
		full_scale_model  = v;
	endtask

	task automatic send_random_word;
		int      pick;
		int      ch;
		int      base;
		sample_t smp [5];
		pick = $urandom_range(99);
		if (pick < 15) begin
			send_word(isf_pkg::CH_VERT, sample_t'($urandom), sample_t'($urandom),
				sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
		end else if (pick < 35) begin
			send_word(2'($urandom_range(2)), sample_t'($urandom), sample_t'($urandom),
				sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
		end else begin
			ch = $urandom_range(2);
			drift_level[ch] = int'(clip_sample(drift_level[ch] + $urandom_range(160) - 80));
			base = drift_level[ch];
			if ($urandom_range(9) == 0)
				base = base + $urandom_range(900, 300);
			foreach (smp[i])
				smp[i] = clip_sample(base + $urandom_range(40) - 20);
			if ($urandom_range(3) == 0)
				smp[$urandom_range(4)] = sample_t'($urandom);
			send_word(2'(ch), smp[0], smp[1], smp[2], smp[3], smp[4]);
		end
	endtask

	task automatic test_spike_limit;
		send_word(CH_LEFT, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		send_word(CH_LEFT, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
		send_word(CH_LEFT, 10'd511, 10'd511, 10'd511, 10'd511, 10'd511);
		send_word(CH_LEFT, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
		send_word(CH_LEFT, 10'd1022, 10'd1022, 10'd1022, 10'd1022, 10'd1022);
		send_word(CH_LEFT, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
	endtask

	task automatic test_trimmed_mean;
		send_word(CH_MIDDLE, 10'd1023, 10'd0, 10'd512, 10'd511, 10'd7);
		send_word(CH_MIDDLE, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023);
		send_word(CH_RIGHT, 10'd5, 10'd4, 10'd3, 10'd2, 10'd1);
		send_word(CH_RIGHT, 10'd400, 10'd401, 10'd402, 10'd0, 10'd1023);
	endtask

	task automatic test_vertical_channel;
		send_word(isf_pkg::CH_VERT, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0);
		send_word(isf_pkg::CH_VERT, 10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
		send_word(CH_LEFT, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		send_word(CH_RIGHT, 10'd402, 10'd402, 10'd402, 10'd402, 10'd402);
	endtask

	task automatic test_scaled_overflow;
		write_full_scale(10'd1);
		send_word(isf_pkg::CH_VERT, 10'd655, 10'd0, 10'd0, 10'd0, 10'd0);
		send_word(isf_pkg::CH_VERT, 10'd656, 10'd0, 10'd0, 10'd0, 10'd0);
		send_word(isf_pkg::CH_VERT, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0);
		send_word(CH_MIDDLE, 10'd900, 10'd900, 10'd900, 10'd900, 10'd900);
		send_word(CH_MIDDLE, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
	endtask

	task automatic test_zero_full_scale;
		write_full_scale(10'd0);
		send_word(isf_pkg::CH_VERT, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		send_word(CH_RIGHT, 10'd300, 10'd300, 10'd300, 10'd300, 10'd300);
		send_word(CH_LEFT, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int blocks);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int b = 0; b < blocks; b++) begin
			if (b == 0)
				write_full_scale(sample_t'(isf_pkg::SAMPLE_MAX));
			else if (b == 1)
				write_full_scale(10'd1);
			else if ($urandom_range(19) == 0)
				write_full_scale(10'd0);
			else if ($urandom_range(2) == 0)
				write_full_scale(sample_t'($urandom_range(40, 2)));
			else
				write_full_scale(sample_t'($urandom_range(isf_pkg::SAMPLE_MAX, 1)));
			repeat (BLOCK_WORDS)
				send_random_word();
		end
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_result
		level_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected word: ch %0d level %0d scaled %0d",
						out_channel, filtered_level, scaled_level);
			end else begin
				want = pending_levels.pop_front();
				if (out_channel !== want.ch || filtered_level !== want.level ||
						scaled_level !== want.scaled) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"mismatch: expected ch %0d level %0d scaled %0d,",
							" got ch %0d level %0d scaled %0d"},
							want.ch, want.level, want.scaled,
							out_channel, filtered_level, scaled_level);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		send_idle_pct    = 38;
		recv_idle_pct    = 54;
		full_scale_model = isf_pkg::FS_RESET;
		foreach (window_model[c, i])
			window_model[c][i] = '0;
		foreach (drift_level[c])
			drift_level[c] = $urandom_range(isf_pkg::SAMPLE_MAX);
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		channel     <= '0;
		sample_a    <= '0;
		sample_b    <= '0;
		sample_c    <= '0;
		sample_d    <= '0;
		sample_e    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_spike_limit();
		test_trimmed_mean();
		test_vertical_channel();
		test_scaled_overflow();
		test_zero_full_scale();
		test_random_traffic(38, 54, 7);
		test_random_traffic(54, 38, 7);
		test_random_traffic(0, 0, 7);

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
